FILE: src/ddkf_pkg.sv
//------------------------------------------------------------------------------
// ddkf_pkg
// Shared types and constants of the drug decay kill factor block.
//------------------------------------------------------------------------------
`default_nettype none
package ddkf_pkg;

    localparam int NUM_PROTEOMES = 4;
    localparam int PROT_W = 2;
    localparam int ADDR_W = 5;

    localparam logic [17:0] KILL_MAX_Q16 = 18'd249037;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    typedef enum logic [1:0] {
        KIND_DOSE  = 2'd0,
        KIND_TICK  = 2'd1,
        KIND_QUERY = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    localparam logic [2:0] REG_DECAY = 3'd0;
    localparam logic [2:0] REG_PD0   = 3'd1;
    localparam logic [2:0] REG_PD3   = 3'd4;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] dose;
        logic [31:0] param;
    } t_cmd;

    typedef struct packed {
        logic [15:0] drug_factor;
        logic        factor_valid;
        logic [31:0] concentration_now;
    } t_res;

endpackage
`default_nettype wire

FILE: src/ddkf_if.sv
//------------------------------------------------------------------------------
// ddkf_in_if / ddkf_out_if
// Valid/ready channels of the drug decay kill factor block.
//------------------------------------------------------------------------------
`default_nettype none
interface ddkf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] dose;
    logic [1:0]  proteome_index;
    modport source (output valid, kind, dose, proteome_index, input ready);
    modport sink (input valid, kind, dose, proteome_index, output ready);
endinterface

interface ddkf_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] drug_factor;
    logic        factor_valid;
    logic [31:0] concentration_now;
    modport source (output valid, drug_factor, factor_valid, concentration_now,
                    input ready);
    modport sink (input valid, drug_factor, factor_valid, concentration_now,
                  output ready);
endinterface
`default_nettype wire

FILE: src/ddkf_front.sv
//------------------------------------------------------------------------------
// ddkf_front
// Accepts items, resolves the parameter slot and queues commands.
//------------------------------------------------------------------------------
`default_nettype none
module ddkf_front
    import ddkf_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire logic [1:0]   i_kind,
    input  wire logic [31:0]  i_dose,
    input  wire logic [1:0]   i_proteome_index,
    input  wire logic [127:0] i_params,
    output logic              o_cmd_valid,
    input  wire logic         i_cmd_ready,
    output t_cmd              o_cmd
);
    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic [1:0] w_slot;
    logic       w_push, w_pop;

    assign o_ready     = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_valid && o_ready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;
    assign w_slot      = (i_proteome_index > PROT_W'(NUM_PROTEOMES - 1)) ?
                         PROT_W'(NUM_PROTEOMES - 1) : i_proteome_index;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp].kind  <= t_kind'(i_kind);
            r_q[r_wp].dose  <= i_dose;
            r_q[r_wp].param <= i_params[w_slot*32 +: 32];
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3)
        else $error("queue count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !w_pop) |=> r_cnt == 2'd2)
        else $error("queue lost an entry");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> !w_pop)
        else $error("pop from empty queue");
endmodule
`default_nettype wire

FILE: src/ddkf_back.sv
//------------------------------------------------------------------------------
// ddkf_back
// Executes commands: concentration update, kill rate division and exp(-m).
//------------------------------------------------------------------------------
`default_nettype none
module ddkf_back
    import ddkf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cmd_valid,
    output logic             o_cmd_ready,
    input  wire t_cmd        i_cmd,
    input  wire logic [15:0] i_decay,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_res             o_res
);
    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_DECAY = 11'b00000000010,
        ST_DSET  = 11'b00000000100,
        ST_DIV   = 11'b00000001000,
        ST_SCALE = 11'b00000010000,
        ST_MEAN  = 11'b00000100000,
        ST_RED   = 11'b00001000000,
        ST_HORN  = 11'b00010000000,
        ST_HDIV  = 11'b00100000000,
        ST_ROUND = 11'b01000000000,
        ST_OUT   = 11'b10000000000
    } t_state;

    t_state      r_st;
    logic [31:0] r_cur, r_nxt, r_p;
    logic        r_which;
    logic [32:0] r_den;
    logic [48:0] r_rem;
    logic [16:0] r_quo;
    logic [5:0]  r_cnt;
    logic [19:0] r_s1;
    logic [20:0] r_m;
    logic [36:0] r_big;
    logic [31:0] r_t;
    logic [4:0]  r_n;
    logic [32:0] r_x;
    logic [3:0]  r_k;
    logic [31:0] r_q;
    t_res        r_res;
    logic        r_ov;

    logic [32:0] w_dsum;
    logic [47:0] w_dec;
    logic [49:0] w_trial;
    logic [31:0] w_c;
    logic [35:0] w_s;
    logic [63:0] w_tx;
    logic [32:0] w_magic;
    logic [64:0] w_recip;
    logic [31:0] w_hq;
    logic [33:0] w_rnd;
    logic [33:0] w_y;

    assign o_cmd_ready = (r_st == ST_IDLE) && !r_ov;
    assign o_valid     = r_ov;
    assign o_res       = r_res;
    assign w_dsum  = {1'b0, r_cur} + {1'b0, i_cmd.dose};
    assign w_dec   = r_cur * i_decay;
    assign w_trial = {r_rem, 1'b0} - {17'd0, r_den};
    assign w_c     = r_which ? r_nxt : r_cur;
    assign w_s     = {19'd0, r_quo} * KILL_MAX_Q16;
    assign w_tx    = r_t * r_x;
    assign w_magic = (r_k == 4'd5) ? 33'h0_CCCC_CCCD :
                     (r_k == 4'd7) ? 33'h1_2492_4925 : 33'h0_AAAA_AAAB;
    assign w_recip = r_q * w_magic;
    assign w_rnd   = {1'b0, r_x} + (34'd1 << (15 + r_n));
    assign w_y     = w_rnd >> (16 + r_n);

    // Division of the Horner term by the series index, by shift or reciprocal.
    always_comb begin
        case (r_k)
            4'd1: w_hq = r_q;
            4'd2: w_hq = {1'b0, r_q[31:1]};
            4'd3: w_hq = w_recip[64:33];
            4'd4: w_hq = {2'b0, r_q[31:2]};
            4'd5: w_hq = {1'b0, w_recip[64:34]};
            4'd6: w_hq = {1'b0, w_recip[64:34]};
            4'd7: w_hq = {2'b0, w_recip[64:35]};
            4'd8: w_hq = {3'b0, r_q[31:3]};
            default: w_hq = r_q;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= ST_IDLE;
            r_cur <= '0;
            r_nxt <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (r_ov && i_ready) r_ov <= 1'b0;
            case (r_st)
                ST_IDLE: begin
                    if (i_cmd_valid && !r_ov) begin
                        r_p <= i_cmd.param;
                        r_res.drug_factor  <= '0;
                        r_res.factor_valid <= 1'b0;
                        case (i_cmd.kind)
                            KIND_DOSE: begin
                                r_cur <= w_dsum[32] ? '1 : w_dsum[31:0];
                                r_st  <= ST_DECAY;
                            end
                            KIND_TICK: begin
                                r_cur <= r_nxt;
                                r_st  <= ST_DECAY;
                            end
                            KIND_QUERY: begin
                                r_which <= 1'b0;
                                r_st    <= ST_DSET;
                            end
                            default: r_st <= ST_OUT;
                        endcase
                    end
                end
                ST_DECAY: begin
                    r_nxt <= w_dec[47:16];
                    r_st  <= ST_OUT;
                end
                ST_DSET: begin
                    r_den <= {1'b0, w_c} + {1'b0, r_p};
                    r_rem <= {17'd0, w_c};
                    r_quo <= '0;
                    r_cnt <= 6'd0;
                    r_st  <= ST_DIV;
                end
                ST_DIV: begin
                    // Restoring division of c*2^16 by c+p, one bit per cycle.
                    if (w_c == 32'd0) begin
                        r_quo <= '0;
                        r_st  <= ST_SCALE;
                    end else if (r_p == 32'd0) begin
                        r_quo <= 17'h1_0000;
                        r_st  <= ST_SCALE;
                    end else begin
                        if (!w_trial[49]) begin
                            r_rem <= w_trial[48:0];
                            r_quo <= {r_quo[15:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[47:0], 1'b0};
                            r_quo <= {r_quo[15:0], 1'b0};
                        end
                        r_cnt <= r_cnt + 6'd1;
                        if (r_cnt == 6'd15) r_st <= ST_SCALE;
                    end
                end
                ST_SCALE: begin
                    if (!r_which) begin
                        r_s1    <= w_s[35:16];
                        r_which <= 1'b1;
                        r_st    <= ST_DSET;
                    end else begin
                        r_m  <= ({1'b0, r_s1} + {1'b0, w_s[35:16]}) >> 1;
                        r_st <= ST_MEAN;
                    end
                end
                ST_MEAN: begin
                    r_big <= {r_m[20:0], 16'd0};
                    r_n   <= '0;
                    r_st  <= ST_RED;
                end
                ST_RED: begin
                    if (r_big >= {5'd0, LN2_Q32} && r_n != 5'd17) begin
                        r_big <= r_big - {5'd0, LN2_Q32};
                        r_n   <= r_n + 5'd1;
                    end else begin
                        r_t  <= r_big[31:0];
                        r_x  <= 33'h1_0000_0000;
                        r_k  <= 4'd8;
                        r_st <= ST_HORN;
                    end
                end
                ST_HORN: begin
                    r_q  <= w_tx[63:32];
                    r_st <= ST_HDIV;
                end
                ST_HDIV: begin
                    r_x <= 33'h1_0000_0000 - {1'b0, w_hq};
                    r_k <= r_k - 4'd1;
                    if (r_k == 4'd1) r_st <= ST_ROUND;
                    else r_st <= ST_HORN;
                end
                ST_ROUND: begin
                    r_res.factor_valid <= 1'b1;
                    if (r_n > 5'd16) r_res.drug_factor <= '0;
                    else if (w_y > 34'd65535) r_res.drug_factor <= 16'hFFFF;
                    else r_res.drug_factor <= w_y[15:0];
                    r_st <= ST_OUT;
                end
                ST_OUT: begin
                    r_res.concentration_now <= r_cur;
                    r_ov <= 1'b1;
                    r_st <= ST_IDLE;
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_OUT) |=> r_ov)
        else $error("result not presented");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_ready) |=> r_ov && $stable(r_res))
        else $error("stalled result changed");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_HORN) |-> (r_k != 4'd0))
        else $error("series index zero");
endmodule
`default_nettype wire

FILE: src/drug_decay_kill_factor_top.sv
//------------------------------------------------------------------------------
// drug_decay_kill_factor_top
// One-compartment decay model returning a drug survival factor per query.
//------------------------------------------------------------------------------
// Channel  Dir  Payload
// in       in   kind, dose, proteome_index
// out      out  drug_factor, factor_valid, concentration_now
// cfg      in   APB writes of decay_factor and pd_param_0..3
// A dose or tick passes through the decay and output states; a query runs two
// bit-serial divisions, the ln2 reduction loop and eight Horner steps.
// Reset is synchronous, clears the concentrations and sets the decay and parameter registers to their defaults.
// A two-entry queue lets input be accepted while a result waits.
`default_nettype none
module drug_decay_kill_factor_top
    import ddkf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    ddkf_in_if.sink                in_ch,
    ddkf_out_if.source             out_ch,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    logic [15:0]  r_decay;
    logic [31:0]  r_pd [NUM_PROTEOMES];
    logic [127:0] w_params;
    logic [2:0]   w_idx;
    logic         w_cmd_valid, w_cmd_ready;
    t_cmd         w_cmd;
    t_res         w_res;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];
    assign w_params = {r_pd[3], r_pd[2], r_pd[1], r_pd[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay <= 16'd32768;
            for (int i = 0; i < NUM_PROTEOMES; i++) r_pd[i] <= 32'd65536;
        end else if (psel && penable && pwrite) begin
            if (w_idx == REG_DECAY) r_decay <= pwdata[15:0];
            else if (w_idx >= REG_PD0 && w_idx <= REG_PD3)
                r_pd[w_idx[1:0] - 2'd1] <= pwdata;
        end
    end

    always_comb begin
        prdata = '0;
        if (w_idx == REG_DECAY) prdata = {16'd0, r_decay};
        else if (w_idx >= REG_PD0 && w_idx <= REG_PD3) prdata = r_pd[w_idx[1:0] - 2'd1];
    end

    ddkf_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_ch.valid), .o_ready(in_ch.ready),
        .i_kind(in_ch.kind), .i_dose(in_ch.dose),
        .i_proteome_index(in_ch.proteome_index), .i_params(w_params),
        .o_cmd_valid(w_cmd_valid), .i_cmd_ready(w_cmd_ready), .o_cmd(w_cmd)
    );

    ddkf_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(w_cmd_valid), .o_cmd_ready(w_cmd_ready), .i_cmd(w_cmd),
        .i_decay(r_decay),
        .o_valid(out_ch.valid), .i_ready(out_ch.ready), .o_res(w_res)
    );

    assign out_ch.drug_factor       = w_res.drug_factor;
    assign out_ch.factor_valid      = w_res.factor_valid;
    assign out_ch.concentration_now = w_res.concentration_now;
endmodule
`default_nettype wire

FILE: tb/sv/tb_drug_decay_kill_factor_top.sv
//------------------------------------------------------------------------------
// tb_drug_decay_kill_factor_top
// Self-checking bench: drives dose, tick, query and none words with random idling,
// programs the decay and parameter registers between phases and compares each
// result word with a bit-accurate predictor of the concentration and factor.
//------------------------------------------------------------------------------
`default_nettype none
module tb_drug_decay_kill_factor_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ddkf_pkg::*;

    localparam logic [63:0] ONE_Q32 = 64'h1_0000_0000;
    localparam int STALL_LIMIT = 20000;

    class factor_scoreboard;
        logic [15:0] decay;
        logic [31:0] pd [4];
        logic [31:0] conc_now;
        logic [31:0] conc_next;
        t_res        pending[$];
        int          errors;

        function void clear();
            decay = 16'd32768;
            foreach (pd[i]) pd[i] = 32'd65536;
            conc_now = '0;
            conc_next = '0;
            errors = 0;
        endfunction

        function logic [31:0] decayed(logic [31:0] c);
            logic [63:0] prod;
            prod = {32'd0, c} * {48'd0, decay};
            return prod[47:16];
        endfunction

        function logic [63:0] kill_rate(logic [63:0] c, logic [63:0] p);
            logic [63:0] r;
            if (c == 0 || c + p == 0) return 0;
            r = (c << 16) / (c + p);
            return (r * KILL_MAX_Q16) >> 16;
        endfunction

        function logic [15:0] survival(logic [63:0] m);
            logic [63:0] big, n, t, x, y;
            big = m << 16;
            n = big / LN2_Q32;
            t = big - n * LN2_Q32;
            x = ONE_Q32;
            if (n > 16) return 0;
            for (int k = 8; k >= 1; k--) x = ONE_Q32 - ((t * x) >> 32) / k;
            y = (x + (64'd1 << (15 + n))) >> (16 + n);
            return (y > 65535) ? 16'hFFFF : y[15:0];
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            if (idx == REG_DECAY) decay = val[15:0];
            else if (idx <= REG_PD3) pd[2'(idx - REG_PD0)] = val;
        endfunction

        function void note_word(t_kind kind, logic [31:0] dose, logic [1:0] slot);
            t_res r;
            logic [32:0] sum;
            logic [31:0] p;
            r = '0;
            case (kind)
                KIND_DOSE: begin
                    sum = {1'b0, conc_now} + {1'b0, dose};
                    conc_now = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    conc_next = decayed(conc_now);
                end
                KIND_TICK: begin
                    conc_now = conc_next;
                    conc_next = decayed(conc_now);
                end
                KIND_QUERY: begin
                    p = pd[slot];
                    r.drug_factor = survival((kill_rate(conc_now, p)
                        + kill_rate(conc_next, p)) >> 1);
                    r.factor_valid = 1'b1;
                end
                default: ;
            endcase
            r.concentration_now = conc_now;
            pending.push_back(r);
        endfunction

        function void check_word(t_res got);
            t_res exp_r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (exp_r.drug_factor != got.drug_factor) begin
                $display("%0t: drug_factor expected %0d actual %0d", $time,
                         exp_r.drug_factor, got.drug_factor);
                errors++;
            end
            if (exp_r.factor_valid != got.factor_valid) begin
                $display("%0t: factor_valid expected %0d actual %0d", $time,
                         exp_r.factor_valid, got.factor_valid);
                errors++;
            end
            if (exp_r.concentration_now != got.concentration_now) begin
                $display("%0t: concentration_now expected %h actual %h", $time,
                         exp_r.concentration_now, got.concentration_now);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    ddkf_in_if  in_ch();
    ddkf_out_if out_ch();

    drug_decay_kill_factor_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch.sink),
        .out_ch(out_ch.source), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    factor_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off = 1'b0;
    int quiet_cycles = 0;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.kind = '0;
        in_ch.dose = '0;
        in_ch.proteome_index = '0;
        out_ch.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_word('{out_ch.drug_factor, out_ch.factor_valid,
                            out_ch.concentration_now});
        if (i_rst_n)
            out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("drug_decay_kill_factor_top regression: fail");
            $finish;
        end
    end

    task automatic send_word(t_kind kind, logic [31:0] dose, logic [1:0] slot);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.kind <= kind;
        in_ch.dose <= dose;
        in_ch.proteome_index <= slot;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_word(kind, dose, slot);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic random_word();
        int sel;
        logic [31:0] d;
        sel = $urandom_range(99);
        case ($urandom_range(3))
            0: d = $urandom;
            1: d = $urandom_range(32'h0010_0000);
            2: d = $urandom_range(255);
            default: d = $urandom_range(32'h0400_0000);
        endcase
        if (sel < 30) send_word(KIND_DOSE, d, 2'($urandom));
        else if (sel < 55) send_word(KIND_TICK, $urandom, 2'($urandom));
        else if (sel < 95) send_word(KIND_QUERY, $urandom, 2'($urandom));
        else send_word(KIND_NONE, $urandom, 2'($urandom));
    endtask

    task automatic random_config(bit extreme);
        write_reg(REG_DECAY, extreme ? ($urandom_range(1) ? 32'hFFFF : 32'h0)
                                     : $urandom_range(32'hFFFF));
        for (int i = int'(REG_PD0); i <= int'(REG_PD3); i++)
            case ($urandom_range(4))
                0: write_reg(3'(i), 32'h0);
                1: write_reg(3'(i), 32'hFFFF_FFFF);
                2: write_reg(3'(i), $urandom);
                default: write_reg(3'(i), $urandom_range(32'h0040_0000));
            endcase
    endtask

    initial begin
        int idle_phase [4][2] = '{'{0, 0}, '{65, 0}, '{0, 65}, '{10, 10}};
        sb.clear();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(KIND_QUERY, 32'h0, 2'd0);
        send_word(KIND_TICK, 32'h0, 2'd0);
        send_word(KIND_DOSE, 32'h0001_0000, 2'd0);
        for (int s = 0; s < 4; s++) send_word(KIND_QUERY, 32'h0, 2'(s));
        send_word(KIND_TICK, 32'hFFFF_FFFF, 2'd3);
        send_word(KIND_QUERY, 32'h0, 2'd1);
        send_word(KIND_DOSE, 32'hFFFF_FFFF, 2'd3);
        send_word(KIND_DOSE, 32'hFFFF_FFFF, 2'd0);
        send_word(KIND_QUERY, 32'h0, 2'd2);
        send_word(KIND_NONE, 32'hFFFF_FFFF, 2'd3);
        drain();
        write_reg(REG_DECAY, 32'hFFFF);
        write_reg(REG_PD0, 32'h0);
        write_reg(REG_PD0 + 3'd1, 32'hFFFF_FFFF);
        write_reg(REG_PD0 + 3'd2, 32'h1);
        write_reg(REG_PD3, 32'h0000_8000);
        for (int s = 0; s < 4; s++) send_word(KIND_QUERY, 32'h0, 2'(s));
        send_word(KIND_TICK, 32'h0, 2'd0);
        send_word(KIND_QUERY, 32'h0, 2'd0);
        drain();
        write_reg(REG_DECAY, 32'h0);
        send_word(KIND_TICK, 32'h0, 2'd0);
        send_word(KIND_QUERY, 32'h0, 2'd1);
        send_word(KIND_TICK, 32'h0, 2'd0);
        send_word(KIND_QUERY, 32'h0, 2'd0);
        drain();

        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            repeat (12) random_word();
        join
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            random_config(ph == 0 || ph == 5);
            send_idle_pct = idle_phase[ph % 4][0];
            recv_stall_pct = idle_phase[ph % 4][1];
            repeat (128) random_word();
            drain();
        end
        write_reg(REG_DECAY, 32'h8000);

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("drug_decay_kill_factor_top regression: pass");
        else
            $display("drug_decay_kill_factor_top regression: fail");
        $finish;
    end
endmodule
`default_nettype wire
